FILE: rtl/svg_pkg.sv
package svg_pkg;

    localparam int MAX_SLICES = 1024;
    localparam int MAX_RINGS  = 1024;

    localparam int CNT_W  = 11;
    localparam int RAD_W  = 16;
    localparam int NUM_W  = 27;
    localparam int QUO_W  = 17;
    localparam int DIV_ST = 17;
    localparam int SIN_ST = 4;

    // pipeline: input stage, divider, sine, product, output
    localparam int ST_DIV0 = 1;
    localparam int ST_SIN0 = ST_DIV0 + DIV_ST;
    localparam int ST_PROD = ST_SIN0 + SIN_ST;
    localparam int NS      = ST_PROD + 2;

    localparam logic [1:0] CFG_SLICES = 2'd0;
    localparam logic [1:0] CFG_RINGS  = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    localparam logic [30:0] SIN_A = 31'd1686629713;
    localparam logic [26:0] SIN_C = 27'd76016977;
    localparam logic [29:0] SIN_B = 30'd688904866;

    localparam logic [CNT_W-1:0] SLICE_MAX_C = CNT_W'(MAX_SLICES);
    localparam logic [CNT_W-1:0] RING_MAX_C  = CNT_W'(MAX_RINGS);

    typedef logic [DIV_ST-1:0] div_ld_t;
    typedef logic [SIN_ST-1:0] sin_ld_t;

endpackage

FILE: rtl/svg_div.sv
module svg_div
    import svg_pkg::*;
(
    input  logic                     aclk,
    input  div_ld_t                  ld,
    input  logic [NUM_W-1:0]         num,
    input  logic [CNT_W-1:0]         den,
    output logic [QUO_W-1:0]         quo
);

    logic [CNT_W-1:0] rem_reg [DIV_ST];
    logic [QUO_W-1:0] low_reg [DIV_ST];
    logic [QUO_W-1:0] q_reg   [DIV_ST];

    genvar j;
    generate
        for (j = 0; j < DIV_ST; j++) begin : g_st
            logic [CNT_W-1:0] rem_in;
            logic [QUO_W-1:0] low_in;
            logic [QUO_W-1:0] q_in;
            logic [CNT_W:0]   trial;
            logic             fit;

            if (j == 0) begin : g_first
                assign rem_in = {1'b0, num[NUM_W-1:QUO_W]};
                assign low_in = num[QUO_W-1:0];
                assign q_in   = '0;
            end else begin : g_rest
                assign rem_in = rem_reg[j-1];
                assign low_in = low_reg[j-1];
                assign q_in   = q_reg[j-1];
            end

            assign trial = {rem_in, low_in[QUO_W-1]};
            assign fit   = trial >= {1'b0, den};

            always_ff @(posedge aclk) begin
                if (ld[j]) begin
                    rem_reg[j] <= fit ? CNT_W'(trial - {1'b0, den}) : trial[CNT_W-1:0];
                    low_reg[j] <= {low_in[QUO_W-2:0], 1'b0};
                    q_reg[j]   <= {q_in[QUO_W-2:0], fit};
                end
            end
        end
    endgenerate

    assign quo = q_reg[DIV_ST-1];

endmodule

FILE: rtl/svg_qsin.sv
module svg_qsin
    import svg_pkg::*;
(
    input  logic               aclk,
    input  sin_ld_t            ld,
    input  logic [15:0]        phase,
    output logic signed [15:0] sin_out
);

    logic [14:0] z0;
    logic [29:0] zz;
    logic [30:0] z2_0;

    logic [30:0] z2_1_reg;
    logic [14:0] z_1_reg;
    logic        neg_1_reg;

    logic [57:0] p1;
    logic [29:0] u_next;
    logic [29:0] u_2_reg;
    logic [30:0] z2_2_reg;
    logic [14:0] z_2_reg;
    logic        neg_2_reg;

    logic [60:0] p2;
    logic [30:0] w_next;
    logic [30:0] w_3_reg;
    logic [14:0] z_3_reg;
    logic        neg_3_reg;

    logic [45:0] p3;
    logic [15:0] mag;
    logic signed [15:0] sin_reg;

    assign z0   = phase[14] ? 15'd16384 - {1'b0, phase[13:0]} : {1'b0, phase[13:0]};
    assign zz   = 30'(z0 * z0);
    assign z2_0 = {zz[28:0], 2'b00};

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            z2_1_reg  <= z2_0;
            z_1_reg   <= z0;
            neg_1_reg <= phase[15];
        end
    end

    assign p1     = 58'(SIN_C) * 58'(z2_1_reg) + 58'(1 << 29);
    assign u_next = SIN_B - p1[57:30];

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            u_2_reg   <= u_next;
            z2_2_reg  <= z2_1_reg;
            z_2_reg   <= z_1_reg;
            neg_2_reg <= neg_1_reg;
        end
    end

    assign p2     = 61'(u_2_reg) * 61'(z2_2_reg) + 61'(1 << 29);
    assign w_next = SIN_A - p2[60:30];

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            w_3_reg   <= w_next;
            z_3_reg   <= z_2_reg;
            neg_3_reg <= neg_2_reg;
        end
    end

    assign p3  = 46'(w_3_reg) * 46'(z_3_reg) + 46'(1 << 29);
    assign mag = p3[45:30];

    always_ff @(posedge aclk) begin
        if (ld[3]) begin
            sin_reg <= neg_3_reg ? -$signed(mag) : $signed(mag);
        end
    end

    assign sin_out = sin_reg;

endmodule

FILE: rtl/sphere_vertex_generator.sv
// UV sphere vertex generator: each input beat (ring, slice) gives one output
// beat with position, normal, tangent and texture coordinates of that grid
// point. Fully pipelined: one beat per cycle while the output is not stalled,
// with 17-stage restoring dividers for the angle phases and tex_v and a
// four-stage sine polynomial. Stalls on the output side fill bubbles first.
// Write the registers only while no beat is in flight.
module sphere_vertex_generator
    import svg_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ring_index[10:0], slice_index[21:11], zero pad
    input  logic [23:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tangent_x, tangent_z,
    // tex_u, tex_v, zero pad
    output logic [167:0] m_tdata
);

    logic [CNT_W-1:0] slice_count_reg;
    logic [CNT_W-1:0] ring_count_reg;
    logic [RAD_W-1:0] sphere_radius_reg;
    logic [CNT_W-1:0] slices;
    logic [CNT_W-1:0] rings;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] ld;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_count_reg   <= 11'd16;
            ring_count_reg    <= 11'd16;
            sphere_radius_reg <= 16'd256;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SLICES: slice_count_reg   <= cfg_data[CNT_W-1:0];
                CFG_RINGS:  ring_count_reg    <= cfg_data[CNT_W-1:0];
                CFG_RADIUS: sphere_radius_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign slices = (slice_count_reg == '0) ? CNT_W'(1) :
                    (slice_count_reg > SLICE_MAX_C) ? SLICE_MAX_C : slice_count_reg;
    assign rings  = (ring_count_reg == '0) ? CNT_W'(1) :
                    (ring_count_reg > RING_MAX_C) ? RING_MAX_C : ring_count_reg;

    always_comb begin
        ld[NS-1] = !vld_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            ld[k] = !vld_reg[k] || ld[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (ld[k]) begin
                    vld_reg[k] <= (k == 0) ? s_tvalid : vld_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    assign s_tready = ld[0];
    assign m_tvalid = vld_reg[NS-1];

    // input stage: clamp and form dividends
    logic [CNT_W-1:0] r_c;
    logic [CNT_W-1:0] s_c;
    logic [NUM_W-1:0] n_rot_reg;
    logic [NUM_W-1:0] n_phi_reg;
    logic [NUM_W-1:0] n_v_reg;

    assign r_c = (s_tdata[10:0] > rings)   ? rings  : s_tdata[10:0];
    assign s_c = (s_tdata[21:11] > slices) ? slices : s_tdata[21:11];

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            n_rot_reg <= {s_c, 16'b0} + NUM_W'(slices[CNT_W-1:1]);
            n_phi_reg <= {1'b0, r_c, 15'b0} + NUM_W'(rings[CNT_W-1:1]);
            n_v_reg   <= {r_c, 16'b0} + NUM_W'(rings[CNT_W-1:1]);
        end
    end

    logic [QUO_W-1:0] q_rot;
    logic [QUO_W-1:0] q_phi;
    logic [QUO_W-1:0] q_v;

    svg_div u_div_rot (
        .aclk (aclk),
        .ld   (ld[ST_SIN0-1:ST_DIV0]),
        .num  (n_rot_reg),
        .den  (slices),
        .quo  (q_rot)
    );

    svg_div u_div_phi (
        .aclk (aclk),
        .ld   (ld[ST_SIN0-1:ST_DIV0]),
        .num  (n_phi_reg),
        .den  (rings),
        .quo  (q_phi)
    );

    svg_div u_div_v (
        .aclk (aclk),
        .ld   (ld[ST_SIN0-1:ST_DIV0]),
        .num  (n_v_reg),
        .den  (rings),
        .quo  (q_v)
    );

    logic signed [15:0] sr;
    logic signed [15:0] cr;
    logic signed [15:0] sp;
    logic signed [15:0] cp;

    svg_qsin u_sin_rot (
        .aclk    (aclk),
        .ld      (ld[ST_PROD-1:ST_SIN0]),
        .phase   (q_rot[15:0]),
        .sin_out (sr)
    );

    svg_qsin u_cos_rot (
        .aclk    (aclk),
        .ld      (ld[ST_PROD-1:ST_SIN0]),
        .phase   (q_rot[15:0] + 16'h4000),
        .sin_out (cr)
    );

    svg_qsin u_sin_phi (
        .aclk    (aclk),
        .ld      (ld[ST_PROD-1:ST_SIN0]),
        .phase   (q_phi[15:0]),
        .sin_out (sp)
    );

    svg_qsin u_cos_phi (
        .aclk    (aclk),
        .ld      (ld[ST_PROD-1:ST_SIN0]),
        .phase   (q_phi[15:0] + 16'h4000),
        .sin_out (cp)
    );

    // texture coordinates ride alongside the sine, product and output stages
    logic [16:0] tu_reg [ST_SIN0:NS-1];
    logic [16:0] tv_reg [ST_SIN0:NS-1];

    always_ff @(posedge aclk) begin
        for (int k = ST_SIN0; k <= NS - 1; k++) begin
            if (ld[k]) begin
                if (k == ST_SIN0) begin
                    tu_reg[k] <= 17'h10000 - q_rot;
                    tv_reg[k] <= q_v;
                end else begin
                    tu_reg[k] <= tu_reg[(k == ST_SIN0) ? ST_SIN0 : k - 1];
                    tv_reg[k] <= tv_reg[(k == ST_SIN0) ? ST_SIN0 : k - 1];
                end
            end
        end
    end

    // first product stage
    logic [14:0] ms, mc, mp, mcp;
    logic [30:0] ry_prod, nx_prod, nz_prod;
    logic [16:0] py_mag;
    logic [15:0] nx_mag, nz_mag;

    logic [30:0]        ax_reg, az_reg;
    logic [14:0]        mp_reg;
    logic               sx_reg, sz_reg, pole_reg;
    logic signed [16:0] py_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg, tx_reg, tz_reg;

    assign ms  = sr[15] ? 15'(-sr) : sr[14:0];
    assign mc  = cr[15] ? 15'(-cr) : cr[14:0];
    assign mp  = sp[15] ? 15'(-sp) : sp[14:0];
    assign mcp = cp[15] ? 15'(-cp) : cp[14:0];

    assign ry_prod = 31'(sphere_radius_reg * mcp) + 31'(8192);
    assign nx_prod = 31'(ms * mp) + 31'(8192);
    assign nz_prod = 31'(mc * mp) + 31'(8192);
    assign py_mag  = ry_prod[30:14];
    assign nx_mag  = nx_prod[29:14];
    assign nz_mag  = nz_prod[29:14];

    always_ff @(posedge aclk) begin
        if (ld[ST_PROD]) begin
            ax_reg   <= 31'(sphere_radius_reg * ms);
            az_reg   <= 31'(sphere_radius_reg * mc);
            mp_reg   <= mp;
            sx_reg   <= sr[15] ^ sp[15];
            sz_reg   <= cr[15] ^ sp[15];
            pole_reg <= (sp == '0);
            py_reg   <= cp[15] ? -$signed(py_mag) : $signed(py_mag);
            nx_reg   <= (sr[15] ^ sp[15]) ? -$signed(nx_mag) : $signed(nx_mag);
            nz_reg   <= (cr[15] ^ sp[15]) ? -$signed(nz_mag) : $signed(nz_mag);
            ny_reg   <= cp;
            tx_reg   <= -cr;
            tz_reg   <= sr;
        end
    end

    // output stage
    logic [45:0] px_prod, pz_prod;
    logic [16:0] px_mag, pz_mag;
    logic        rad_zero;

    assign px_prod  = 46'(ax_reg) * 46'(mp_reg) + 46'(1 << 27);
    assign pz_prod  = 46'(az_reg) * 46'(mp_reg) + 46'(1 << 27);
    assign px_mag   = px_prod[44:28];
    assign pz_mag   = pz_prod[44:28];
    assign rad_zero = (sphere_radius_reg == '0);

    logic signed [16:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic signed [15:0] normal_x_reg, normal_y_reg, normal_z_reg;
    logic signed [15:0] tangent_x_reg, tangent_z_reg;

    always_ff @(posedge aclk) begin
        if (ld[NS-1]) begin
            pos_x_reg     <= rad_zero ? '0 : (sx_reg ? -$signed(px_mag) : $signed(px_mag));
            pos_z_reg     <= rad_zero ? '0 : (sz_reg ? -$signed(pz_mag) : $signed(pz_mag));
            pos_y_reg     <= rad_zero ? '0 : py_reg;
            normal_x_reg  <= rad_zero ? '0 : nx_reg;
            normal_y_reg  <= rad_zero ? '0 : ny_reg;
            normal_z_reg  <= rad_zero ? '0 : nz_reg;
            tangent_x_reg <= (rad_zero || pole_reg) ? '0 : tx_reg;
            tangent_z_reg <= (rad_zero || pole_reg) ? '0 : tz_reg;
        end
    end

    assign m_tdata = {3'b000, tv_reg[NS-1], tu_reg[NS-1], tangent_z_reg,
                      tangent_x_reg, normal_z_reg, normal_y_reg, normal_x_reg,
                      pos_z_reg, pos_y_reg, pos_x_reg};

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready) else $error("input held off with output free");

    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> (!m_tvalid && s_tready)) else $error("pipe not empty after reset");

    a_out_from_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(vld_reg[NS-2])) else $error("output beat from nowhere");

endmodule

FILE: dv/sphere_vertex_generator_chk.sv
`timescale 1ns / 100ps

module sphere_vertex_generator_chk
    import svg_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [23:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [167:0] m_tdata,
    output int           fail_count,
    output int           vertices_pending
);

    localparam int FOFF [10] = '{0, 17, 34, 51, 67, 83, 99, 115, 131, 148};
    localparam int FWID [10] = '{17, 17, 17, 16, 16, 16, 16, 16, 17, 17};
    localparam string FNAME [10] = '{"pos_x", "pos_y", "pos_z", "normal_x", "normal_y",
                                     "normal_z", "tangent_x", "tangent_z", "tex_u", "tex_v"};

    localparam longint unsigned QA = 64'd1686629713;
    localparam longint unsigned QC = 64'd76016977;
    localparam longint unsigned QB = QA + QC - (64'd1 << 30);

    logic [10:0] slices_q, rings_q;
    logic [15:0] radius_q;
    logic [167:0] vertex_q[$];

    assign vertices_pending = vertex_q.size();

    function automatic longint quarter_wave(longint unsigned z);
        longint unsigned z2, t, u, t2, w;
        z2 = (z * z) << 2;
        t  = (QC * z2 + (64'd1 << 29)) >> 30;
        u  = QB - t;
        t2 = (u * z2 + (64'd1 << 29)) >> 30;
        w  = QA - t2;
        return longint'((w * z + (64'd1 << 29)) >> 30);
    endfunction

    function automatic longint phase_sine(longint unsigned p);
        longint unsigned x;
        x = p & 64'h3FFF;
        case ((p >> 14) & 3)
            0: return quarter_wave(x);
            1: return quarter_wave(16384 - x);
            2: return -quarter_wave(x);
            default: return -quarter_wave(16384 - x);
        endcase
    endfunction

    function automatic longint round_product(longint a, longint b, int sh);
        longint unsigned ma, mb, p;
        bit neg;
        neg = (a < 0) != (b < 0);
        ma = a < 0 ? longint'(-a) : a;
        mb = b < 0 ? longint'(-b) : b;
        p = (ma * mb + (64'd1 << (sh - 1))) >> sh;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [167:0] vertex_predict(logic [10:0] ri, logic [10:0] si);
        longint unsigned slices, rings, r, s, rot_full, rot_p, phi_p, v;
        longint rad, sr, cr, sp, cp;
        logic [167:0] vx;
        slices = slices_q == 0 ? 1 : (slices_q > MAX_SLICES ? MAX_SLICES : slices_q);
        rings = rings_q == 0 ? 1 : (rings_q > MAX_RINGS ? MAX_RINGS : rings_q);
        r = ri > rings ? rings : ri;
        s = si > slices ? slices : si;
        rad = radius_q;
        rot_full = (s * 65536 + slices / 2) / slices;
        rot_p = rot_full & 64'hFFFF;
        phi_p = (r * 32768 + rings / 2) / rings;
        v = (r * 65536 + rings / 2) / rings;
        sr = phase_sine(rot_p);
        cr = phase_sine((rot_p + 16384) & 64'hFFFF);
        sp = phase_sine(phi_p);
        cp = phase_sine((phi_p + 16384) & 64'hFFFF);
        vx = '0;
        if (rad != 0) begin
            vx[16:0]   = 17'(round_product(rad * sr, sp, 28));
            vx[33:17]  = 17'(round_product(rad, cp, 14));
            vx[50:34]  = 17'(round_product(rad * cr, sp, 28));
            vx[66:51]  = 16'(round_product(sr, sp, 14));
            vx[82:67]  = 16'(cp);
            vx[98:83]  = 16'(round_product(cr, sp, 14));
            if (sp != 0) begin
                vx[114:99]  = 16'(-cr);
                vx[130:115] = 16'(sr);
            end
        end
        vx[147:131] = 17'(65536 - rot_full);
        vx[164:148] = 17'(v);
        return vx;
    endfunction

    always @(posedge aclk) begin
        logic [167:0] want;
        longint unsigned ev, av;
        int errs;
        if (!aresetn) begin
            slices_q <= 11'd16;
            rings_q <= 11'd16;
            radius_q <= 16'd256;
            vertex_q.delete();
            fail_count <= 0;
        end else begin
            errs = 0;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SLICES: slices_q <= cfg_data[10:0];
                    CFG_RINGS:  rings_q <= cfg_data[10:0];
                    CFG_RADIUS: radius_q <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                vertex_q.insert(vertex_q.size(),
                                vertex_predict(s_tdata[10:0], s_tdata[21:11]));
            if (m_tvalid && m_tready) begin
                if (vertex_q.size() == 0) begin
                    $display("%0t: unexpected vertex beat %h", $time, m_tdata);
                    errs++;
                end else begin
                    want = vertex_q.pop_front();
                    for (int i = 0; i < 10; i++) begin
                        ev = 64'((want >> FOFF[i]) & ((64'd1 << FWID[i]) - 1));
                        av = 64'((m_tdata >> FOFF[i]) & ((64'd1 << FWID[i]) - 1));
                        if (ev != av) begin
                            $display("%0t: %s expected %h actual %h", $time, FNAME[i], ev, av);
                            errs++;
                        end
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end

endmodule

FILE: dv/sphere_vertex_generator_tb.sv
`timescale 1ns / 100ps

module sphere_vertex_generator_tb
    import svg_pkg::*;
();

    localparam logic [1:0] CFG_NONE = 2'd3;

    logic         aclk;
    logic         aresetn;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [15:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [23:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [167:0] m_tdata;
    int           fail_count;
    int           vertices_pending;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           cycle_count = 0;
    logic [10:0]  cur_slices, cur_rings;

    sphere_vertex_generator dut (.*);

    sphere_vertex_generator_chk chk (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic drain_pipe();
        while (vertices_pending != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_SLICES) cur_slices = val[10:0];
        if (idx == CFG_RINGS) cur_rings = val[10:0];
    endtask

    task automatic send_vertex(logic [10:0] ring, logic [10:0] slice);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, slice, ring};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        drain_pipe();
    endtask

    task automatic random_grid(int n);
        logic [10:0] r, s;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                r = 11'($urandom);
                s = 11'($urandom);
            end else begin
                r = 11'($urandom_range(cur_rings + 1));
                s = 11'($urandom_range(cur_slices + 1));
            end
            send_vertex(r, s);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SLICES;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cur_slices = 11'd16;
        cur_rings = 11'd16;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_vertex(11'd0, 11'd0);
        send_vertex(11'd16, 11'd16);
        send_vertex(11'd8, 11'd4);
        send_vertex(11'd1024, 11'd1024);
        send_vertex(11'h7FF, 11'h7FF);
        send_vertex(11'h555, 11'h2AA);
        send_vertex(11'h2AA, 11'h555);
        end_burst();
        write_reg(CFG_RADIUS, 16'd0);
        send_vertex(11'd5, 11'd3);
        send_vertex(11'd0, 11'd0);
        end_burst();
        write_reg(CFG_RADIUS, 16'hFFFF);
        write_reg(CFG_SLICES, 16'd1);
        write_reg(CFG_RINGS, 16'd1);
        send_vertex(11'd0, 11'd0);
        send_vertex(11'd1, 11'd1);
        send_vertex(11'd0, 11'd1);
        end_burst();
        write_reg(CFG_SLICES, 16'd0);
        write_reg(CFG_RINGS, 16'd0);
        write_reg(CFG_NONE, 16'h1234);
        send_vertex(11'd1, 11'd1);
        send_vertex(11'd3, 11'd7);
        end_burst();
        write_reg(CFG_SLICES, 16'hFFFF);
        write_reg(CFG_RINGS, 16'h07FF);
        send_vertex(11'd1024, 11'd1024);
        send_vertex(11'd512, 11'd256);
        send_vertex(11'd1023, 11'd1);
        end_burst();
        write_reg(CFG_SLICES, 16'd1024);
        write_reg(CFG_RINGS, 16'd1024);
        send_vertex(11'd1024, 11'd1023);
        send_vertex(11'd1, 11'd512);
        end_burst();

        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            write_reg(CFG_SLICES, 16'(($urandom_range(3) == 0) ? $urandom_range(1024)
                                                               : $urandom_range(1, 40)));
            write_reg(CFG_RINGS, 16'(($urandom_range(3) == 0) ? $urandom_range(1024)
                                                              : $urandom_range(1, 40)));
            write_reg(CFG_RADIUS, ($urandom_range(5) == 0) ? 16'd0 : 16'($urandom));
            random_grid(50);
            end_burst();
            random_grid(50);
            end_burst();
        end

        end_burst();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sphere_vertex_generator.f
rtl/svg_pkg.sv
rtl/svg_div.sv
rtl/svg_qsin.sv
rtl/sphere_vertex_generator.sv
dv/sphere_vertex_generator_chk.sv
dv/sphere_vertex_generator_tb.sv
